[hw/rtl/tfr_pkg.sv]
// Shared types and constants of the TCP first-record reassembler.
`default_nettype none

package tfr_pkg;

  localparam int SEQ_W        = 32;
  localparam int BYTE_W       = 8;
  localparam int READ_IDX_W   = 12;
  localparam int PREFIX_OUT_W = 13;
  localparam int WORD_BITS    = 32;
  localparam int WORD_IDX_W   = 5;

  typedef enum logic [1:0] {
    OP_SET_ISN = 2'd0,
    OP_FEED    = 2'd1,
    OP_READ    = 2'd2,
    OP_CONSUME = 2'd3
  } op_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } zero_hit_t;

  function automatic zero_hit_t find_zero(input logic [WORD_BITS-1:0] word);
    zero_hit_t hit;
    hit.found = 1'b0;
    hit.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        hit.found = 1'b1;
        hit.idx   = WORD_IDX_W'(i);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcp_first_record_reassembler.sv]
// Top level of the TCP first-record reassembler: sequencer, shared adder and stores.
// Each item passes IDLE, EXEC and RESP; a prefix read adds READ, a fed byte adds CHECK unless
// consume came first, and a byte in the window and not yet in the prefix adds MODIFY, then WALK
// for each further 32-byte bitmap word walked. RESP waits while a held result is not taken.
// Throughput: one item at a time; the bitmap walk over the held-byte RAM sets the worst case.
// Reset is synchronous and active low; a clearing pass then zeroes each bitmap word before any item is taken.
`default_nettype none

module tcp_first_record_reassembler import tfr_pkg::*; #(
  parameter int WINDOW_BYTES = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_op,
  input  wire logic [SEQ_W-1:0]        in_seq,
  input  wire logic [BYTE_W-1:0]       in_data_byte,
  input  wire logic                    in_last_of_segment,
  input  wire logic [READ_IDX_W-1:0]   in_read_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [BYTE_W-1:0]       out_read_byte,
  output logic      [PREFIX_OUT_W-1:0] out_prefix_length,
  output logic                         out_grew,
  output logic                         out_finished
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int PW = $clog2(WINDOW_BYTES + 1);
  localparam int NW = (WINDOW_BYTES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW = $clog2(NW);
  localparam int LW = WW + WORD_IDX_W + 1;
  localparam int CW = (PW > READ_IDX_W) ? PW : READ_IDX_W;
  localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW_BYTES);
  localparam logic [LW-1:0]    WIN_L   = LW'(WINDOW_BYTES);
  localparam logic [WW-1:0]    LAST_W  = WW'(NW - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_MODIFY,
    ST_WALK,
    ST_READ,
    ST_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [WW-1:0]        clr_cnt_r, clr_cnt_nxt;
  op_t                  op_r, op_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [BYTE_W-1:0]    data_r, data_nxt;
  logic                 last_r, last_nxt;
  logic [READ_IDX_W-1:0] ridx_r, ridx_nxt;
  logic [SEQ_W-1:0]     off_r, off_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic                 base_known_r, base_known_nxt;
  logic [PW-1:0]        prefix_r, prefix_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 seg_open_r, seg_open_nxt;
  logic [PW-1:0]        seg_start_r, seg_start_nxt;
  logic [BYTE_W-1:0]    rbyte_r, rbyte_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_read_byte_r, out_read_byte_nxt;
  logic [PREFIX_OUT_W-1:0] out_prefix_r, out_prefix_nxt;
  logic                 out_grew_r, out_grew_nxt;
  logic                 out_finished_r, out_finished_nxt;

  logic [SEQ_W-1:0]     add_b;
  logic [SEQ_W-1:0]     add_sum;

  logic                 bm_we, bm_re;
  logic [WW-1:0]        bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic                 st_we, st_re;
  logic [AW-1:0]        st_waddr, st_raddr;
  logic [BYTE_W-1:0]    st_rdata;

  logic [WORD_BITS-1:0] merged;
  logic [WORD_BITS-1:0] scan_word;
  logic [WW-1:0]        scan_wi;
  zero_hit_t            scan_hit;
  logic [LW-1:0]        scan_pos, scan_next, scan_cap;
  logic                 scan_more;
  logic [WW-1:0]        off_word, prefix_word;
  logic                 resp_load;

  tfr_ram #(.DATA_W(WORD_BITS), .DEPTH(NW)) u_held_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  tfr_ram #(.DATA_W(BYTE_W), .DEPTH(WINDOW_BYTES)) u_byte_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (data_r),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Shared adder: seq + 1 for the initial sequence, seq - base for a fed byte.
  assign add_b   = (op_r == OP_SET_ISN) ? '0 : ~(base_known_r ? base_r : seq_r);
  assign add_sum = seq_r + add_b + SEQ_W'(1);

  assign off_word    = WW'(off_r[AW-1:WORD_IDX_W]);
  assign prefix_word = WW'(prefix_r[AW-1:WORD_IDX_W]);
  assign merged      = bm_rdata | (WORD_BITS'(1) << off_r[WORD_IDX_W-1:0]);

  assign scan_word = (state_r == ST_MODIFY) ? merged : bm_rdata;
  assign scan_wi   = (state_r == ST_MODIFY) ? off_word : prefix_word;
  assign scan_hit  = find_zero(scan_word);
  assign scan_pos  = LW'({scan_wi, scan_hit.idx});
  assign scan_next = (LW'(scan_wi) + LW'(1)) << WORD_IDX_W;
  assign scan_more = !scan_hit.found && (scan_next < WIN_L);

  always_comb begin
    if (scan_hit.found) begin
      scan_cap = (scan_pos > WIN_L) ? WIN_L : scan_pos;
    end else begin
      scan_cap = (scan_next >= WIN_L) ? WIN_L : scan_next;
    end
  end

  assign resp_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    op_nxt            = op_r;
    seq_nxt           = seq_r;
    data_nxt          = data_r;
    last_nxt          = last_r;
    ridx_nxt          = ridx_r;
    off_nxt           = off_r;
    base_nxt          = base_r;
    base_known_nxt    = base_known_r;
    prefix_nxt        = prefix_r;
    stopped_nxt       = stopped_r;
    seg_open_nxt      = seg_open_r;
    seg_start_nxt     = seg_start_r;
    rbyte_nxt         = rbyte_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_read_byte_nxt = out_read_byte_r;
    out_prefix_nxt    = out_prefix_r;
    out_grew_nxt      = out_grew_r;
    out_finished_nxt  = out_finished_r;
    bm_we             = 1'b0;
    bm_waddr          = off_word;
    bm_wdata          = merged;
    bm_re             = 1'b0;
    bm_raddr          = off_word;
    st_we             = 1'b0;
    st_waddr          = off_r[AW-1:0];
    st_re             = 1'b0;
    st_raddr          = AW'(ridx_r);
    in_ready          = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_cnt_r;
        bm_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + WW'(1);
        if (clr_cnt_r == LAST_W) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = op_t'(in_op);
          seq_nxt   = in_seq;
          data_nxt  = in_data_byte;
          last_nxt  = in_last_of_segment;
          ridx_nxt  = in_read_index;
          rbyte_nxt = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_SET_ISN: begin
            if (!base_known_r) begin
              base_nxt       = add_sum;
              base_known_nxt = 1'b1;
            end
            state_nxt = ST_RESP;
          end
          OP_FEED: begin
            if (stopped_r) begin
              state_nxt = ST_RESP;
            end else begin
              if (!seg_open_r) begin
                seg_open_nxt  = 1'b1;
                seg_start_nxt = prefix_r;
              end
              if (!base_known_r) begin
                base_nxt       = seq_r;
                base_known_nxt = 1'b1;
              end
              off_nxt   = add_sum;
              state_nxt = ST_CHECK;
            end
          end
          OP_READ: begin
            if (CW'(ridx_r) < CW'(prefix_r)) begin
              st_re     = 1'b1;
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          OP_CONSUME: begin
            stopped_nxt   = 1'b1;
            prefix_nxt    = '0;
            seg_open_nxt  = 1'b0;
            seg_start_nxt = '0;
            state_nxt     = ST_RESP;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_CHECK: begin
        if ((off_r >= WIN_SEQ) || (off_r < SEQ_W'(prefix_r))) begin
          state_nxt = ST_RESP;
        end else begin
          bm_re     = 1'b1;
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (bm_rdata[off_r[WORD_IDX_W-1:0]]) begin
          state_nxt = ST_RESP;
        end else begin
          bm_we = 1'b1;
          st_we = 1'b1;
          if (off_r == SEQ_W'(prefix_r)) begin
            prefix_nxt = PW'(scan_cap);
            if (scan_more) begin
              bm_re     = 1'b1;
              bm_raddr  = scan_wi + WW'(1);
              state_nxt = ST_WALK;
            end else begin
              state_nxt = ST_RESP;
            end
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        prefix_nxt = PW'(scan_cap);
        if (scan_more) begin
          bm_re     = 1'b1;
          bm_raddr  = scan_wi + WW'(1);
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ: begin
        rbyte_nxt = st_rdata;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (resp_load) begin
          out_valid_nxt     = 1'b1;
          out_read_byte_nxt = rbyte_r;
          out_prefix_nxt    = PREFIX_OUT_W'(prefix_r);
          out_finished_nxt  = stopped_r;
          out_grew_nxt      = 1'b0;
          if ((op_r == OP_FEED) && last_r) begin
            seg_open_nxt = 1'b0;
            out_grew_nxt = !stopped_r && (prefix_r > seg_start_r);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      base_r         <= '0;
      base_known_r   <= 1'b0;
      prefix_r       <= '0;
      stopped_r      <= 1'b0;
      seg_open_r     <= 1'b0;
      seg_start_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      base_r         <= base_nxt;
      base_known_r   <= base_known_nxt;
      prefix_r       <= prefix_nxt;
      stopped_r      <= stopped_nxt;
      seg_open_r     <= seg_open_nxt;
      seg_start_r    <= seg_start_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    op_r            <= op_nxt;
    seq_r           <= seq_nxt;
    data_r          <= data_nxt;
    last_r          <= last_nxt;
    ridx_r          <= ridx_nxt;
    off_r           <= off_nxt;
    rbyte_r         <= rbyte_nxt;
    out_read_byte_r <= out_read_byte_nxt;
    out_prefix_r    <= out_prefix_nxt;
    out_grew_r      <= out_grew_nxt;
    out_finished_r  <= out_finished_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_read_byte_r;
  assign out_prefix_length = out_prefix_r;
  assign out_grew          = out_grew_r;
  assign out_finished      = out_finished_r;

`ifndef ASSERT_OFF
  a_prefix_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_r <= PW'(WINDOW_BYTES))
    else $error("prefix length beyond the window");

  a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (prefix_r == '0))
    else $error("prefix not empty after consume");

  a_prefix_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !stopped_r) |-> (prefix_r >= $past(prefix_r)))
    else $error("prefix shrank without consume");

  a_grew_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_grew_r) |-> !out_finished_r)
    else $error("growth reported after consume");
`endif

endmodule

`default_nettype wire

[hw/rtl/tfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tfr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
